// File: sv/adl_pkg.sv
// Shared types, constants and helper functions for the audio DMA length FIFO timer.
// Used by adl_div and audio_dma_length_fifo_timer_top; depends on nothing else.
package adl_pkg;

   // Default number of fraction bits of the counts-per-byte rate.
   localparam int FRACTION_BITS_DEF = 16;

   // Field and register widths.
   localparam int CMD_W   = 2;
   localparam int LEN_W   = 18;
   localparam int TICK_W  = 16;
   localparam int CNT_W   = 32;
   localparam int FREQ_W  = 26;
   localparam int CSR_W   = 24;
   localparam int CSRI_W  = 3;
   localparam int MULA_W  = 32;
   localparam int MULB_W  = 18;
   localparam int PROD_W  = MULA_W + MULB_W;

   // Item commands.
   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

   // Configuration register indexes.
   localparam logic [CSRI_W-1:0] CSR_FRAME_RATE = 3'd0;
   localparam logic [CSRI_W-1:0] CSR_VI_COUNTS  = 3'd1;
   localparam logic [CSRI_W-1:0] CSR_DAC_RATE   = 3'd2;
   localparam logic [CSRI_W-1:0] CSR_BIT_RATE   = 3'd3;
   localparam logic [CSRI_W-1:0] CSR_SYS_TYPE   = 3'd4;

   // Video system codes.
   localparam logic [1:0] SYS_PAL  = 2'd1;
   localparam logic [1:0] SYS_MPAL = 2'd2;

   // Constants of the length path and the clocks.
   localparam logic [LEN_W-1:0]  LEN_MASK     = 18'h3FFF8;
   localparam logic [LEN_W-1:0]  LEN_MIN      = 18'd8;
   localparam logic [LEN_W-1:0]  LEN_MAX      = 18'd262136;
   localparam logic [FREQ_W-1:0] CLK_NTSC     = 26'd48681812;
   localparam logic [FREQ_W-1:0] CLK_PAL      = 26'd49656530;
   localparam logic [FREQ_W-1:0] CLK_MPAL     = 26'd48628316;
   localparam logic [CNT_W-1:0]  FALLBACK_DEN = 32'd88200;
   localparam logic [CNT_W-1:0]  CNT_SAT      = 32'hFFFFFFFF;

   // One-hot sequencer states.
   typedef enum logic [15:0] {
      ST_IDLE    = 16'h0001,
      ST_W_NUM   = 16'h0002,
      ST_W_FDIV  = 16'h0004,
      ST_W_DEN   = 16'h0008,
      ST_W_RGO   = 16'h0010,
      ST_W_RDIV  = 16'h0020,
      ST_W_CHK   = 16'h0040,
      ST_W_RDIV2 = 16'h0080,
      ST_W_APPLY = 16'h0100,
      ST_W_TGT   = 16'h0200,
      ST_R_MUL   = 16'h0400,
      ST_R_REM   = 16'h0800,
      ST_R_DIV   = 16'h1000,
      ST_T_CHK   = 16'h2000,
      ST_T_TGT   = 16'h4000,
      ST_OUT     = 16'h8000
   } adl_state_type;

   // Snap a raw sample frequency to the nearest standard rate.
   function automatic logic [FREQ_W-1:0] snap_freq(input logic [FREQ_W-1:0] f);
      logic [FREQ_W-1:0] r;
      r = f;
      if (f > 26'd7000 && f < 26'd9000) r = 26'd8000;
      else if (f > 26'd10000 && f < 26'd12000) r = 26'd11025;
      else if (f > 26'd21000 && f < 26'd23000) r = 26'd22050;
      else if (f > 26'd31000 && f < 26'd33000) r = 26'd32000;
      else if (f > 26'd43000 && f < 26'd45000) r = 26'd44100;
      else if (f > 26'd47000 && f < 26'd49000) r = 26'd48000;
      return r;
   endfunction

   // Timer length from a product: shift out the fraction, saturate to 32 bits.
   function automatic logic [CNT_W-1:0] sat_shift(input logic [PROD_W-1:0] p,
                                                 input int fb);
      logic [PROD_W-1:0] t;
      t = p >> fb;
      return (|t[PROD_W-1:CNT_W]) ? CNT_SAT : t[CNT_W-1:0];
   endfunction

endpackage

// File: sv/adl_div.sv
// Restoring serial divider, one quotient bit per cycle, shared by the sequencer.
// Imports adl_pkg but uses none of its types; divisor is never zero when started.
module adl_div
   import adl_pkg::*;
#(
   parameter int DIVIDEND_W = 48,
   parameter int DIVISOR_W  = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int CW = $clog2(DIVIDEND_W + 1);

   logic [DIVIDEND_W-1:0] q_ff, q_in;
   logic [DIVISOR_W-1:0]  r_ff, r_in;
   logic [DIVISOR_W-1:0]  d_ff, d_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  done_ff, done_in;
   logic [DIVISOR_W:0]    shifted;
   logic [DIVISOR_W:0]    diff;

   // One restoring step: shift in the next dividend bit and try to subtract.
   always_comb begin
      shifted = {r_ff, q_ff[DIVIDEND_W-1]};
      diff    = shifted - {1'b0, d_ff};
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         q_in   = dividend;
         r_in   = '0;
         d_in   = divisor;
         cnt_in = CW'(DIVIDEND_W);
      end else if (cnt_ff != '0) begin
         if (!diff[DIVISOR_W]) begin
            r_in = diff[DIVISOR_W-1:0];
            q_in = {q_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            r_in = shifted[DIVISOR_W-1:0];
            q_in = {q_ff[DIVIDEND_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            done_in = 1'b1;
         end
      end
   end

   // Control state is reset; the data path is not.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

// File: sv/audio_dma_length_fifo_timer_top.sv
// Channel  | Ports                                   | Direction
// ---------+-----------------------------------------+----------
// request  | req_valid, req_stall, req_cmd/length/ticks | in
// response | rsp_valid, rsp_stall, rsp_* result fields  | out
// config   | csr_we, csr_index, csr_wdata             | in
// A length write takes one to three passes of the shared serial divider (the third only
// when the rate comes out zero) plus multiply and bookkeeping steps; a length read takes
// at most one pass; ticks and clears need no divider pass.
// Reset is synchronous and active high; it restores the register defaults and empties
// the FIFO. One item is in work at a time; req_stall is high until its result is taken.
module audio_dma_length_fifo_timer_top
   import adl_pkg::*;
#(
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [CMD_W-1:0]  req_cmd,
   input  logic [LEN_W-1:0]  req_length,
   input  logic [TICK_W-1:0] req_ticks,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [LEN_W-1:0]  rsp_read_length,
   output logic              rsp_status_busy,
   output logic              rsp_status_full,
   output logic              rsp_overflow,
   output logic              rsp_buffer_done,
   output logic              rsp_interrupt,
   input  logic              csr_we,
   input  logic [CSRI_W-1:0] csr_index,
   input  logic [CSR_W-1:0]  csr_wdata
);

   localparam int DW = CNT_W + FRACTION_BITS;

   adl_state_type state_ff, state_in;

   // Configuration registers.
   logic [7:0]        frame_ff;
   logic [23:0]       vicpf_ff;
   logic [13:0]       dac_ff;
   logic [3:0]        brate_ff;
   logic [1:0]        sys_ff;

   // Block state.
   logic [LEN_W-1:0]  slot0_ff, slot0_in, slot1_ff, slot1_in;
   logic [CNT_W-1:0]  elapsed_ff, elapsed_in, target_ff, target_in, cpb_ff, cpb_in;
   logic              busy_ff, busy_in, full_ff, full_in;

   // Item and working registers.
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [CNT_W-1:0]  num_ff, num_in;
   logic [FREQ_W-1:0] freq_ff, freq_in;
   logic [PROD_W-1:0] prod_ff, prod_in;

   // Result registers.
   logic [LEN_W-1:0]  rd_ff, rd_in;
   logic              ovf_ff, ovf_in, done_ff, done_in, intr_ff, intr_in;

   // Shared multiplier and divider controls.
   logic              mul_en;
   logic [MULA_W-1:0] mul_a;
   logic [MULB_W-1:0] mul_b;
   logic              div_start, div_done;
   logic [DW-1:0]     div_dividend, div_quotient;
   logic [CNT_W-1:0]  div_divisor;

   // Helpers.
   logic [FREQ_W-1:0] clk_sel;
   logic [2:0]        bps_div4;
   logic [CNT_W-1:0]  q_sat, set_len, rem;
   logic [CNT_W:0]    tick_sum;
   logic [LEN_W-1:0]  len_masked, rd_capped;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);

   always_comb begin
      case (sys_ff)
         SYS_PAL:  clk_sel = CLK_PAL;
         SYS_MPAL: clk_sel = CLK_MPAL;
         default:  clk_sel = CLK_NTSC;
      endcase
   end

   assign bps_div4   = 3'(({1'b0, brate_ff} + 5'd1) >> 2);
   assign q_sat      = (|div_quotient[DW-1:CNT_W]) ? CNT_SAT : div_quotient[CNT_W-1:0];
   assign set_len    = sat_shift(prod_ff, FRACTION_BITS);
   assign rem        = (set_len > elapsed_ff) ? (set_len - elapsed_ff) : '0;
   assign tick_sum   = {1'b0, elapsed_ff} + {{(CNT_W+1-TICK_W){1'b0}}, req_ticks};
   assign len_masked = len_ff & LEN_MASK;

   // Clamp the remaining byte count and round it down to a multiple of eight.
   always_comb begin
      if (div_quotient < DW'(LEN_MIN)) rd_capped = LEN_MIN;
      else if (div_quotient > DW'(LEN_MAX)) rd_capped = LEN_MAX;
      else rd_capped = div_quotient[LEN_W-1:0] & LEN_MASK;
   end

   // Shared multiplier operand selection.
   always_comb begin
      mul_en = 1'b1;
      mul_a  = '0;
      mul_b  = '0;
      case (state_ff)
         ST_W_NUM:   begin mul_a = MULA_W'(vicpf_ff); mul_b = MULB_W'(frame_ff); end
         ST_W_DEN:   begin mul_a = MULA_W'(freq_ff);  mul_b = MULB_W'(bps_div4); end
         ST_W_APPLY: begin mul_a = cpb_ff; mul_b = len_masked; end
         ST_R_MUL:   begin mul_a = cpb_ff; mul_b = slot0_ff; end
         ST_T_CHK:   begin mul_a = cpb_ff; mul_b = slot1_ff; end
         default:    mul_en = 1'b0;
      endcase
      prod_in = mul_en ? (PROD_W'(mul_a) * PROD_W'(mul_b)) : prod_ff;
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      slot0_in     = slot0_ff;
      slot1_in     = slot1_ff;
      elapsed_in   = elapsed_ff;
      target_in    = target_ff;
      cpb_in       = cpb_ff;
      busy_in      = busy_ff;
      full_in      = full_ff;
      len_in       = len_ff;
      num_in       = num_ff;
      freq_in      = freq_ff;
      rd_in        = rd_ff;
      ovf_in       = ovf_ff;
      done_in      = done_ff;
      intr_in      = intr_ff;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               len_in  = req_length;
               rd_in   = '0;
               ovf_in  = 1'b0;
               done_in = 1'b0;
               intr_in = 1'b0;
               state_in = ST_OUT;
               case (req_cmd)
                  CMD_WRITE: begin
                     if (req_length != '0) state_in = ST_W_NUM;
                  end
                  CMD_READ: begin
                     if (slot0_ff != '0) begin
                        if (cpb_ff == '0) rd_in = slot0_ff;
                        else state_in = ST_R_MUL;
                     end
                  end
                  CMD_TICK: begin
                     elapsed_in = tick_sum[CNT_W] ? CNT_SAT : tick_sum[CNT_W-1:0];
                     state_in   = ST_T_CHK;
                  end
                  default: begin
                     cpb_in    = '0;
                     slot0_in  = '0;
                     slot1_in  = '0;
                     busy_in   = 1'b0;
                     full_in   = 1'b0;
                     target_in = '0;
                     if (req_length != '0) begin
                        elapsed_in = '0;
                        intr_in    = 1'b1;
                     end
                  end
               endcase
            end
         end
         // Numerator product and the sample clock division.
         ST_W_NUM: begin
            div_start    = 1'b1;
            div_dividend = DW'(clk_sel);
            div_divisor  = CNT_W'({1'b0, dac_ff} + 15'd1);
            state_in     = ST_W_FDIV;
         end
         ST_W_FDIV: begin
            if (div_done) begin
               num_in   = prod_ff[CNT_W-1:0];
               freq_in  = snap_freq(div_quotient[FREQ_W-1:0]);
               state_in = ST_W_DEN;
            end
         end
         ST_W_DEN: begin
            state_in = ST_W_RGO;
         end
         // Rate division, saturated when the divisor is zero and the numerator is not.
         ST_W_RGO: begin
            if (prod_ff[CNT_W-1:0] == '0) begin
               cpb_in   = (num_ff != '0) ? CNT_SAT : '0;
               state_in = ST_W_CHK;
            end else begin
               div_start    = 1'b1;
               div_dividend = DW'(num_ff) << FRACTION_BITS;
               div_divisor  = prod_ff[CNT_W-1:0];
               state_in     = ST_W_RDIV;
            end
         end
         ST_W_RDIV: begin
            if (div_done) begin
               cpb_in   = q_sat;
               state_in = ST_W_CHK;
            end
         end
         // Fall back to 22050 Hz at 16 bits when the rate came out zero.
         ST_W_CHK: begin
            if (cpb_ff == '0) begin
               div_start    = 1'b1;
               div_dividend = DW'(num_ff) << FRACTION_BITS;
               div_divisor  = FALLBACK_DEN;
               state_in     = ST_W_RDIV2;
            end else begin
               state_in = ST_W_APPLY;
            end
         end
         ST_W_RDIV2: begin
            if (div_done) begin
               cpb_in   = q_sat;
               state_in = ST_W_APPLY;
            end
         end
         // Place the length in the busy slot, the second slot, or flag overflow.
         ST_W_APPLY: begin
            if (slot0_ff == '0) begin
               state_in = ST_W_TGT;
            end else if (slot1_ff == '0) begin
               slot1_in = len_masked;
               full_in  = 1'b1;
               state_in = ST_OUT;
            end else begin
               full_in  = 1'b1;
               ovf_in   = 1'b1;
               state_in = ST_OUT;
            end
         end
         ST_W_TGT: begin
            elapsed_in = '0;
            slot0_in   = len_masked;
            busy_in    = 1'b1;
            target_in  = set_len;
            state_in   = ST_OUT;
         end
         // Remaining bytes of the current buffer.
         ST_R_MUL: begin
            state_in = ST_R_REM;
         end
         ST_R_REM: begin
            div_start    = 1'b1;
            div_dividend = DW'(rem) << FRACTION_BITS;
            div_divisor  = cpb_ff;
            state_in     = ST_R_DIV;
         end
         ST_R_DIV: begin
            if (div_done) begin
               rd_in    = rd_capped;
               state_in = ST_OUT;
            end
         end
         // Timer expiry: shift the slots and re-arm or go idle.
         ST_T_CHK: begin
            state_in = ST_OUT;
            if (busy_ff && target_ff != '0 && elapsed_ff >= target_ff) begin
               done_in  = 1'b1;
               slot0_in = slot1_ff;
               slot1_in = '0;
               full_in  = 1'b0;
               if (slot1_ff != '0) begin
                  busy_in  = 1'b1;
                  state_in = ST_T_TGT;
               end else begin
                  busy_in   = 1'b0;
                  target_in = '0;
               end
            end
         end
         ST_T_TGT: begin
            target_in  = set_len;
            elapsed_in = '0;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         frame_ff   <= 8'd60;
         vicpf_ff   <= '0;
         dac_ff     <= '0;
         brate_ff   <= 4'd15;
         sys_ff     <= '0;
         slot0_ff   <= '0;
         slot1_ff   <= '0;
         elapsed_ff <= '0;
         target_ff  <= '0;
         cpb_ff     <= '0;
         busy_ff    <= 1'b0;
         full_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         slot0_ff   <= slot0_in;
         slot1_ff   <= slot1_in;
         elapsed_ff <= elapsed_in;
         target_ff  <= target_in;
         cpb_ff     <= cpb_in;
         busy_ff    <= busy_in;
         full_ff    <= full_in;
         if (csr_we) begin
            case (csr_index)
               CSR_FRAME_RATE: frame_ff <= csr_wdata[7:0];
               CSR_VI_COUNTS:  vicpf_ff <= csr_wdata;
               CSR_DAC_RATE:   dac_ff   <= csr_wdata[13:0];
               CSR_BIT_RATE:   brate_ff <= csr_wdata[3:0];
               CSR_SYS_TYPE:   sys_ff   <= csr_wdata[1:0];
               default: ;
            endcase
         end
      end
      len_ff  <= len_in;
      num_ff  <= num_in;
      freq_ff <= freq_in;
      prod_ff <= prod_in;
      rd_ff   <= rd_in;
      ovf_ff  <= ovf_in;
      done_ff <= done_in;
      intr_ff <= intr_in;
   end

   adl_div #(
      .DIVIDEND_W (DW),
      .DIVISOR_W  (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign rsp_read_length = rd_ff;
   assign rsp_status_busy = busy_ff;
   assign rsp_status_full = full_ff;
   assign rsp_overflow    = ovf_ff;
   assign rsp_buffer_done = done_ff;
   assign rsp_interrupt   = intr_ff;

endmodule

// File: dv/audio_dma_length_fifo_timer_top_tb.sv
// Self-checking testbench for the audio DMA length FIFO timer top level.
// Depends on adl_pkg and audio_dma_length_fifo_timer_top; drives items and checks every result.
module audio_dma_length_fifo_timer_top_tb;
   import adl_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FB = FRACTION_BITS_DEF;
   localparam int LIMIT_CYCLES = 2000000;

   typedef struct packed {
      logic [LEN_W-1:0] read_length;
      logic             busy;
      logic             full;
      logic             overflow;
      logic             done;
      logic             intr;
   } status_type;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [LEN_W-1:0]  length;
      logic [TICK_W-1:0] ticks;
      logic              has_fixed;
      status_type        fixed;
   } dir_row_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [CMD_W-1:0]  req_cmd;
   logic [LEN_W-1:0]  req_length;
   logic [TICK_W-1:0] req_ticks;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [LEN_W-1:0]  rsp_read_length;
   logic              rsp_status_busy;
   logic              rsp_status_full;
   logic              rsp_overflow;
   logic              rsp_buffer_done;
   logic              rsp_interrupt;
   logic              csr_we;
   logic [CSRI_W-1:0] csr_index;
   logic [CSR_W-1:0]  csr_wdata;

   audio_dma_length_fifo_timer_top u_top (.*);

   // Predictor state: configuration copy and FIFO/timer state.
   logic [7:0]        m_frame_rate;
   logic [23:0]       m_vi_counts;
   logic [13:0]       m_dac_rate;
   logic [3:0]        m_bit_rate;
   logic [1:0]        m_sys_type;
   logic [LEN_W-1:0]  m_slot [2];
   logic [CNT_W-1:0]  m_elapsed;
   logic [CNT_W-1:0]  m_target;
   logic [CNT_W-1:0]  m_rate_q;
   logic              m_busy;
   logic              m_full;

   status_type        expected_q [$];
   int                fail_count;
   longint            cycle_count = 0;
   int                send_idle_pct;
   int                recv_stall_pct;
   bit                long_hold;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Cycle counter and run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic logic [31:0] std_freq();
      logic [31:0] clk;
      logic [31:0] f;
      clk = CLK_NTSC;
      if (m_sys_type == SYS_PAL) clk = CLK_PAL;
      else if (m_sys_type == SYS_MPAL) clk = CLK_MPAL;
      f = clk / (m_dac_rate + 32'd1);
      if (f > 7000 && f < 9000) f = 8000;
      else if (f > 10000 && f < 12000) f = 11025;
      else if (f > 21000 && f < 23000) f = 22050;
      else if (f > 31000 && f < 33000) f = 32000;
      else if (f > 43000 && f < 45000) f = 44100;
      else if (f > 47000 && f < 49000) f = 48000;
      return f;
   endfunction

   function automatic logic [31:0] fixed_div(input logic [63:0] num, input logic [63:0] den);
      logic [127:0] q;
      if (den == 0) return (num != 0) ? CNT_SAT : 32'd0;
      q = ({64'd0, num} << FB) / den;
      return (q > 128'hFFFFFFFF) ? CNT_SAT : q[31:0];
   endfunction

   function automatic logic [31:0] timer_counts(input logic [LEN_W-1:0] len);
      logic [63:0] t;
      t = ({32'd0, m_rate_q} * len) >> FB;
      return (t > 64'hFFFFFFFF) ? CNT_SAT : t[31:0];
   endfunction

   // Advances the predictor by one item and returns the expected result.
   function automatic status_type predict_status(input logic [CMD_W-1:0] cmd,
                                                 input logic [LEN_W-1:0] len,
                                                 input logic [TICK_W-1:0] ticks);
      status_type  s;
      logic [63:0] num;
      logic [63:0] den;
      logic [63:0] r;
      logic [31:0] set;
      logic [31:0] rem;
      logic [32:0] sum;
      s = '0;
      case (cmd)
         CMD_WRITE: begin
            if (len != 0) begin
               num = 64'(m_frame_rate) * 64'(m_vi_counts);
               den = 64'(std_freq()) * 64'((m_bit_rate + 5'd1) / 4);
               m_rate_q = fixed_div(num, den);
               if (m_rate_q == 0) m_rate_q = fixed_div(num, 64'd88200);
               if (m_slot[0] == 0) begin
                  m_elapsed = 0;
                  m_slot[0] = len & LEN_MASK;
                  m_busy = 1'b1;
                  m_target = timer_counts(m_slot[0]);
               end else if (m_slot[1] == 0) begin
                  m_slot[1] = len & LEN_MASK;
                  m_full = 1'b1;
               end else begin
                  m_full = 1'b1;
                  s.overflow = 1'b1;
               end
            end
         end
         CMD_READ: begin
            if (m_slot[0] != 0) begin
               if (m_rate_q == 0) begin
                  r = m_slot[0];
               end else begin
                  set = timer_counts(m_slot[0]);
                  rem = (set > m_elapsed) ? set - m_elapsed : 32'd0;
                  r = ({32'd0, rem} << FB) / m_rate_q;
               end
               if (r < 8) r = 8;
               if (r > 262136) r = 262136;
               s.read_length = r[LEN_W-1:0] & ~18'h7;
            end
         end
         CMD_TICK: begin
            sum = {1'b0, m_elapsed} + 33'(ticks);
            m_elapsed = sum[32] ? CNT_SAT : sum[31:0];
            if (m_busy && m_target != 0 && m_elapsed >= m_target) begin
               s.done = 1'b1;
               m_slot[0] = m_slot[1];
               m_slot[1] = 0;
               m_full = 1'b0;
               if (m_slot[0] != 0) begin
                  m_target = timer_counts(m_slot[0]);
                  m_elapsed = 0;
               end else begin
                  m_busy = 1'b0;
                  m_target = 0;
               end
            end
         end
         default: begin
            m_rate_q = 0;
            m_slot[0] = 0;
            m_slot[1] = 0;
            m_busy = 1'b0;
            m_full = 1'b0;
            m_target = 0;
            if (len != 0) begin
               m_elapsed = 0;
               s.intr = 1'b1;
            end
         end
      endcase
      s.busy = m_busy;
      s.full = m_full;
      return s;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch in %s: got %0h, expected %0h at cycle %0d", what, got, want,
               cycle_count);
      fail_count++;
   endtask

   // Receiver: random stalls, optional long hold, checks every accepted item.
   always @(posedge clock) begin
      status_type e;
      if (reset) begin
         rsp_stall <= 1'b1;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               report_mismatch("unexpected result", 0, 0);
            end else begin
               e = expected_q.pop_front();
               if (rsp_read_length !== e.read_length)
                  report_mismatch("read_length", rsp_read_length, e.read_length);
               if (rsp_status_busy !== e.busy)
                  report_mismatch("status_busy", rsp_status_busy, e.busy);
               if (rsp_status_full !== e.full)
                  report_mismatch("status_full", rsp_status_full, e.full);
               if (rsp_overflow !== e.overflow)
                  report_mismatch("overflow", rsp_overflow, e.overflow);
               if (rsp_buffer_done !== e.done)
                  report_mismatch("buffer_done", rsp_buffer_done, e.done);
               if (rsp_interrupt !== e.intr)
                  report_mismatch("interrupt", rsp_interrupt, e.intr);
            end
         end
         rsp_stall <= long_hold || ($urandom_range(99, 0) < recv_stall_pct);
      end
   end

   // Long hold-off on the receiver, counted here while the sender keeps offering items.
   initial begin
      long_hold = 1'b0;
      wait (send_idle_pct == 0 && recv_stall_pct == 0 && !reset);
      repeat (50) @(posedge clock);
      long_hold <= 1'b1;
      repeat (600) @(posedge clock);
      long_hold <= 1'b0;
   end

   // Writes one register, then waits with csr_we low so that writes never overlap.
   task automatic write_csr(input logic [CSRI_W-1:0] idx, input logic [CSR_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_FRAME_RATE: m_frame_rate = val[7:0];
         CSR_VI_COUNTS:  m_vi_counts  = val[23:0];
         CSR_DAC_RATE:   m_dac_rate   = val[13:0];
         CSR_BIT_RATE:   m_bit_rate   = val[3:0];
         CSR_SYS_TYPE:   m_sys_type   = val[1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Offers one item, waits for acceptance, and records its expectation.
   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [LEN_W-1:0] len,
                            input logic [TICK_W-1:0] ticks, input bit has_fixed,
                            input status_type fixed);
      status_type s;
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_cmd    <= cmd;
      req_length <= len;
      req_ticks  <= ticks;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      s = predict_status(cmd, len, ticks);
      expected_q.push_back(has_fixed ? fixed : s);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   // Random item mix biased toward well-formed write, tick and read sequences.
   task automatic random_items(input int count);
      int          pick;
      logic [LEN_W-1:0]  len;
      logic [TICK_W-1:0] tk;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99, 0);
         len  = ($urandom_range(9, 0) == 0) ? LEN_W'($urandom) : LEN_W'($urandom_range(64, 0));
         tk   = ($urandom_range(4, 0) == 0) ? TICK_W'($urandom)
                                             : TICK_W'($urandom_range(300, 0));
         if (pick < 35) send_item(CMD_WRITE, len, tk, 1'b0, '0);
         else if (pick < 55) send_item(CMD_READ, len, tk, 1'b0, '0);
         else if (pick < 95) send_item(CMD_TICK, len, tk, 1'b0, '0);
         else send_item(CMD_CLEAR, LEN_W'($urandom_range(1, 0)) * len, tk, 1'b0, '0);
      end
   endtask

   dir_row_type directed_rows [] = '{
      // After reset: read with empty slot, tick with idle timer.
      '{CMD_READ,  18'd0,      16'd0,     1'b1, '{18'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{CMD_TICK,  18'd0,      16'hFFFF,  1'b1, '{18'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
      // Zero length write is ignored.
      '{CMD_WRITE, 18'd0,      16'd0,     1'b1, '{18'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
      // Zero rate: timer off, read returns the whole slot.
      '{CMD_WRITE, 18'h3FFFF,  16'd0,     1'b1, '{18'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{CMD_READ,  18'd0,      16'd0,     1'b1, '{18'd262136, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{CMD_WRITE, 18'd16,     16'd0,     1'b1, '{18'd0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0}},
      // Overflow when both slots hold a length.
      '{CMD_WRITE, 18'd24,     16'd0,     1'b1, '{18'd0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0}},
      '{CMD_TICK,  18'd0,      16'hFFFF,  1'b1, '{18'd0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0}},
      // Clear with nonzero length raises the interrupt.
      '{CMD_CLEAR, 18'h3FFFF,  16'hFFFF,  1'b1, '{18'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1}},
      '{CMD_CLEAR, 18'd0,      16'd0,     1'b1, '{18'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
      // Short length masks to an empty slot, then is filled again.
      '{CMD_WRITE, 18'd7,      16'd0,     1'b1, '{18'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{CMD_READ,  18'd0,      16'd0,     1'b1, '{18'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{CMD_WRITE, 18'd8,      16'd0,     1'b1, '{18'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{CMD_CLEAR, 18'd1,      16'd0,     1'b1, '{18'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1}}
   };

   dir_row_type timed_rows [] = '{
      // With a running timer: fill, read, expire, re-arm, expire again.
      '{CMD_WRITE, 18'd40,     16'd0,     1'b0, '0},
      '{CMD_WRITE, 18'd17,     16'd0,     1'b0, '0},
      '{CMD_READ,  18'd0,      16'd0,     1'b0, '0},
      '{CMD_TICK,  18'd0,      16'd5,     1'b0, '0},
      '{CMD_READ,  18'd0,      16'd0,     1'b0, '0},
      '{CMD_TICK,  18'd0,      16'hFFFF,  1'b0, '0},
      '{CMD_TICK,  18'd0,      16'hFFFF,  1'b0, '0},
      '{CMD_TICK,  18'd0,      16'hFFFF,  1'b0, '0},
      '{CMD_READ,  18'd0,      16'd0,     1'b0, '0},
      '{CMD_CLEAR, 18'd5,      16'd0,     1'b0, '0}
   };

   // Main sequence: reset, directed tables, then configured random phases.
   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_cmd = CMD_WRITE;
      req_length = '0;
      req_ticks = '0;
      csr_we = 1'b0;
      csr_index = CSR_FRAME_RATE;
      csr_wdata = '0;
      fail_count = 0;
      send_idle_pct = 47;
      recv_stall_pct = 47;
      m_frame_rate = 8'd60;
      m_vi_counts = 0;
      m_dac_rate = 0;
      m_bit_rate = 4'd15;
      m_sys_type = 0;
      m_slot[0] = 0;
      m_slot[1] = 0;
      m_elapsed = 0;
      m_target = 0;
      m_rate_q = 0;
      m_busy = 1'b0;
      m_full = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 0;
      recv_stall_pct = 0;
      foreach (directed_rows[i])
         send_item(directed_rows[i].cmd, directed_rows[i].length, directed_rows[i].ticks,
                   directed_rows[i].has_fixed, directed_rows[i].fixed);
      drain();
      write_csr(CSR_VI_COUNTS, 24'd800000);
      write_csr(CSR_SYS_TYPE, CSR_W'(SYS_PAL));
      write_csr(CSR_DAC_RATE, 24'd1124);
      foreach (timed_rows[i])
         send_item(timed_rows[i].cmd, timed_rows[i].length, timed_rows[i].ticks,
                   1'b0, '0);
      random_items(110);
      drain();

      // Small rate so that ticks expire buffers often; sender idle phase.
      send_idle_pct = 47;
      write_csr(CSR_FRAME_RATE, 24'd1);
      write_csr(CSR_VI_COUNTS, 24'd2000);
      write_csr(CSR_BIT_RATE, 24'd7);
      write_csr(CSR_SYS_TYPE, CSR_W'(SYS_MPAL));
      random_items(110);
      drain();

      // Receiver stalling; zero divisor saturates the rate.
      send_idle_pct = 0;
      recv_stall_pct = 47;
      write_csr(CSR_BIT_RATE, 24'd2);
      write_csr(CSR_SYS_TYPE, 24'd3);
      write_csr(CSR_DAC_RATE, 24'h3FFF);
      random_items(110);
      drain();

      // Both idling; register extremes.
      send_idle_pct = 18;
      recv_stall_pct = 18;
      write_csr(CSR_FRAME_RATE, 24'hFF);
      write_csr(CSR_VI_COUNTS, 24'hFFFFFF);
      write_csr(CSR_BIT_RATE, 24'd15);
      write_csr(CSR_DAC_RATE, 24'd0);
      write_csr(CSR_SYS_TYPE, 24'd0);
      random_items(100);
      drain();

      // Zero divisor with a moderate numerator saturates the rate; no idling.
      send_idle_pct = 0;
      recv_stall_pct = 0;
      write_csr(CSR_FRAME_RATE, 24'd50);
      write_csr(CSR_VI_COUNTS, 24'd300);
      write_csr(CSR_BIT_RATE, 24'd0);
      write_csr(CSR_DAC_RATE, 24'd2000);
      random_items(100);
      drain();

      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Leftover expectations keep the drain waiting until the cycle limit fails the run.
endmodule
